>>> sv/repg_pkg.sv
// ----------------------------------------------------------------------------
// repg_pkg: shared definitions for the rotated ellipse point generator
// Register indexes, CORDIC constants, arctangent table and the status word
// passed from the rotator to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package repg_pkg;

    // configuration port widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // fixed field widths
    localparam int INDEX_W = 16;
    localparam int PIXEL_W = 12;
    localparam int COUNT_W = 16;
    localparam int TRIG_W  = 16;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTER_X     = 3'd0,
        CFG_CENTER_Y     = 3'd1,
        CFG_SEMI_AXIS_A  = 3'd2,
        CFG_SEMI_AXIS_B  = 3'd3,
        CFG_ORIENTATION  = 3'd4,
        CFG_N_POINTS     = 3'd5,
        CFG_IMAGE_WIDTH  = 3'd6,
        CFG_IMAGE_HEIGHT = 3'd7
    } cfg_index_t;

    // cordic gain in q2.30, start value of x
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam int ATAN_ENTRIES = 24;

    // rotator status word
    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [15:0] sin_val;
        logic signed [15:0] cos_val;
    } repg_trig_t;

    // arctangent of 2^-k as a 32-bit fraction of a turn
    function automatic logic [31:0] repg_atan(input logic [4:0] k);
        logic [31:0] a;
        case (k)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051D;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

>>> sv/repg_cordic.sv
// ----------------------------------------------------------------------------
// repg_cordic: iterative sine and cosine rotator
// One shift-add rotation per cycle on a q2.30 vector; the angle is a 32-bit
// fraction of a turn. Results are rounded and saturated to q1.15.
// ----------------------------------------------------------------------------
`default_nettype none

module repg_cordic #(
    parameter int ITERATIONS = 16
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    input  wire [31:0]              turn,
    output repg_pkg::repg_trig_t    trig
);
    import repg_pkg::*;

    localparam int KBW = $clog2(ITERATIONS);

    logic                busy_reg;
    logic                done_reg;
    logic                flip_reg;
    logic [KBW-1:0]      k_reg;
    logic signed [32:0]  x_reg;
    logic signed [32:0]  y_reg;
    logic signed [33:0]  z_reg;

    logic                flip_in;
    logic [31:0]         turn_red;
    logic signed [32:0]  x_shift;
    logic signed [32:0]  y_shift;
    logic signed [33:0]  atan_k;
    logic signed [32:0]  x_fin;
    logic signed [32:0]  y_fin;

    // round to q1.15 and saturate
    function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
        logic signed [33:0] t;
        logic signed [18:0] r;
        logic signed [15:0] q;
        t = $signed({v[32], v}) + 34'sd16384;
        r = t[33:15];
        if (r > 19'sd32767)
            q = 16'sh7FFF;
        else if (r < -19'sd32768)
            q = 16'sh8000;
        else
            q = r[15:0];
        return q;
    endfunction

    // second and third quadrant fold back by half a turn
    assign flip_in  = turn[31] ^ turn[30];
    assign turn_red = {turn[31] ^ flip_in, turn[30:0]};

    // shifted operands and table angle for this step
    assign x_shift = x_reg >>> k_reg;
    assign y_shift = y_reg >>> k_reg;
    assign atan_k  = $signed({2'b00, repg_atan(5'(k_reg))});

    // rotation steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg + 1'b1;
                if (k_reg == KBW'(ITERATIONS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // vector and residual angle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({{2{turn_red[31]}}, turn_red});
            flip_reg <= flip_in;
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - y_shift;
                y_reg <= y_reg + x_shift;
                z_reg <= z_reg - atan_k;
            end
            else
            begin
                x_reg <= x_reg + y_shift;
                y_reg <= y_reg - x_shift;
                z_reg <= z_reg + atan_k;
            end
        end
    end

    // undo the fold and round
    assign x_fin = flip_reg ? -x_reg : x_reg;
    assign y_fin = flip_reg ? -y_reg : y_reg;

    assign trig.busy    = busy_reg;
    assign trig.done    = done_reg;
    assign trig.sin_val = to_q15(y_fin);
    assign trig.cos_val = to_q15(x_fin);

endmodule

`default_nettype wire

>>> sv/rotated_ellipse_point_generator_unit.sv
// ----------------------------------------------------------------------------
// rotated_ellipse_point_generator_unit: points on a rotated ellipse
// Phase i/N by a restoring divider, sine and cosine by a shared CORDIC,
// rotation by one shared multiplier, then the image bounds check and the
// running outside count.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  -------   -------------------   ------------------------------------------
//  in        in_valid / in_ready   point_index
//  out       out_valid / out_ready column, row, inside_res, outside_count
//  cfg       cfg_we                cfg_index, cfg_data
//
//  From accept to the next accept an item passes the divider at one quotient
//  bit per cycle, then the CORDIC at one rotation per cycle, which runs once
//  for the orientation and once for the phase, then six multiplies.
//  The result waits in the output register; a new word is accepted meanwhile
//  and only the final state stalls until the previous result is taken.
//  Reset clears control, the outside count and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_ellipse_point_generator_unit #(
    parameter int COORD_BITS      = 12,
    parameter int ANGLE_BITS      = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire [repg_pkg::INDEX_W-1:0]         point_index,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [repg_pkg::PIXEL_W-1:0]        column,
    output logic [repg_pkg::PIXEL_W-1:0]        row,
    output logic                                inside_res,
    output logic [repg_pkg::COUNT_W-1:0]        outside_count,
    input  wire                                 cfg_we,
    input  wire [repg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [repg_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import repg_pkg::*;

    localparam int DIV_STEPS = INDEX_W + ANGLE_BITS;
    localparam int DCW       = $clog2(DIV_STEPS);
    localparam int MW        = (COORD_BITS > 12) ? COORD_BITS : 12;
    localparam int DW        = COORD_BITS + 17;
    localparam int PRW       = DW + TRIG_W;
    localparam int AW        = PRW + 1;
    localparam int XW        = COORD_BITS + 21;
    localparam int WW        = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;
    localparam int KW        = (XW > WW + 17) ? XW : WW + 17;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_ORI  = 6'b000100,
        S_PHS  = 6'b001000,
        S_MUL  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        M_DX = 3'd0,
        M_DY = 3'd1,
        M_XA = 3'd2,
        M_XB = 3'd3,
        M_YA = 3'd4,
        M_YB = 3'd5
    } mul_step_t;

    // configuration registers
    logic [11:0]            cx_reg;
    logic [11:0]            cy_reg;
    logic [11:0]            sa_reg;
    logic [11:0]            sb_reg;
    logic [15:0]            ori_reg;
    logic [15:0]            np_reg;
    logic [12:0]            iw_reg;
    logic [12:0]            ih_reg;

    // control
    state_t                 state_reg;
    state_t                 state_next;
    logic [DCW-1:0]         div_cnt_reg;
    mul_step_t              mstep_reg;
    logic                   out_valid_reg;
    logic [COUNT_W-1:0]     tally_reg;
    logic [COUNT_W-1:0]     tally_next;

    // datapath
    logic [INDEX_W-1:0]     idx_reg;
    logic [INDEX_W-1:0]     dvd_reg;
    logic [15:0]            rem_reg;
    logic [ANGLE_BITS-1:0]  q_reg;
    logic signed [15:0]     so_reg;
    logic signed [15:0]     co_reg;
    logic signed [15:0]     sp_reg;
    logic signed [15:0]     cp_reg;
    logic signed [DW-1:0]   dx_reg;
    logic signed [DW-1:0]   dy_reg;
    logic signed [AW-1:0]   accx_reg;
    logic signed [AW-1:0]   accy_reg;
    logic [PIXEL_W-1:0]     column_reg;
    logic [PIXEL_W-1:0]     row_reg;
    logic                   inside_reg;

    logic                   accept;
    logic                   div_last;
    logic [16:0]            rem_sh;
    logic                   rem_ge;
    logic [16:0]            rem_sub;
    logic [ANGLE_BITS-1:0]  phase;
    logic [31:0]            trig_turn;
    logic                   trig_start;
    repg_trig_t             trig;
    logic signed [DW-1:0]   op_a;
    logic signed [15:0]     op_b;
    logic signed [PRW-1:0]  prod;
    logic signed [AW-1:0]   prod_ext;
    logic [MW-1:0]          cx_ext;
    logic [MW-1:0]          cy_ext;
    logic [MW-1:0]          sa_ext;
    logic [MW-1:0]          sb_ext;
    logic [COORD_BITS-1:0]  cx_m;
    logic [COORD_BITS-1:0]  cy_m;
    logic [COORD_BITS-1:0]  sa_m;
    logic [COORD_BITS-1:0]  sb_m;
    logic signed [AW-1:0]   x_sh;
    logic signed [AW-1:0]   y_sh;
    logic [XW-1:0]          x_val;
    logic [XW-1:0]          y_val;
    logic [WW-1:0]          cmax;
    logic [WW-1:0]          iw_ext;
    logic [WW-1:0]          ih_ext;
    logic [WW-1:0]          w_lim;
    logic [WW-1:0]          h_lim;
    logic                   x_ok;
    logic                   y_ok;
    logic                   pt_inside;
    logic                   load_out;
    logic [COUNT_W-1:0]     tally_base;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= 12'd0;
            cy_reg  <= 12'd0;
            sa_reg  <= 12'd1;
            sb_reg  <= 12'd1;
            ori_reg <= 16'd0;
            np_reg  <= 16'd3;
            iw_reg  <= 13'd4096;
            ih_reg  <= 13'd4096;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_X:     cx_reg  <= cfg_data[11:0];
                CFG_CENTER_Y:     cy_reg  <= cfg_data[11:0];
                CFG_SEMI_AXIS_A:  sa_reg  <= cfg_data[11:0];
                CFG_SEMI_AXIS_B:  sb_reg  <= cfg_data[11:0];
                CFG_ORIENTATION:  ori_reg <= cfg_data;
                CFG_N_POINTS:     np_reg  <= cfg_data;
                CFG_IMAGE_WIDTH:  iw_reg  <= cfg_data[12:0];
                CFG_IMAGE_HEIGHT: ih_reg  <= cfg_data[12:0];
                default:          ;
            endcase
        end
    end

    // coordinates and axes masked to the coordinate width
    assign cx_ext = MW'(cx_reg);
    assign cy_ext = MW'(cy_reg);
    assign sa_ext = MW'(sa_reg);
    assign sb_ext = MW'(sb_reg);
    assign cx_m   = cx_ext[COORD_BITS-1:0];
    assign cy_m   = cy_ext[COORD_BITS-1:0];
    assign sa_m   = sa_ext[COORD_BITS-1:0];
    assign sb_m   = sb_ext[COORD_BITS-1:0];

    // handshake
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    // restoring divider step, index bits first, then zeros
    assign div_last = (div_cnt_reg == DCW'(DIV_STEPS - 1));
    assign rem_sh   = {rem_reg, dvd_reg[INDEX_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, np_reg});
    assign rem_sub  = rem_sh - {1'b0, np_reg};
    assign phase    = (np_reg == 16'd0) ? '0 : q_reg;

    // rotator angle: orientation first, then the phase
    assign trig_turn  = (state_reg == S_DIV) ? {ori_reg, 16'h0000}
                                             : (32'(phase) << (32 - ANGLE_BITS));
    assign trig_start = ((state_reg == S_DIV) && div_last)
                     || ((state_reg == S_ORI) && trig.done);

    repg_cordic #(
        .ITERATIONS (TRIG_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .turn  (trig_turn),
        .trig  (trig)
    );

    // shared multiplier operand select
    always_comb
    begin
        case (mstep_reg)
            M_DX:
            begin
                op_a = $signed(DW'(sa_m));
                op_b = cp_reg;
            end
            M_DY:
            begin
                op_a = $signed(DW'(sb_m));
                op_b = sp_reg;
            end
            M_XA:
            begin
                op_a = dx_reg;
                op_b = co_reg;
            end
            M_XB:
            begin
                op_a = dy_reg;
                op_b = so_reg;
            end
            M_YA:
            begin
                op_a = dx_reg;
                op_b = so_reg;
            end
            M_YB:
            begin
                op_a = dy_reg;
                op_b = co_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod     = op_a * op_b;
    assign prod_ext = $signed({prod[PRW-1], prod});

    // floor to 16 fraction bits and add the centre
    assign x_sh  = accx_reg >>> 14;
    assign y_sh  = accy_reg >>> 14;
    assign x_val = x_sh[XW-1:0] + XW'({cx_m, 16'h0000});
    assign y_val = y_sh[XW-1:0] + XW'({cy_m, 16'h0000});

    // image size clamped to the coordinate range
    assign cmax   = WW'({1'b1, {COORD_BITS{1'b0}}});
    assign iw_ext = WW'(iw_reg);
    assign ih_ext = WW'(ih_reg);
    assign w_lim  = (iw_ext > cmax) ? cmax : iw_ext;
    assign h_lim  = (ih_ext > cmax) ? cmax : ih_ext;

    // bounds check
    assign x_ok      = !x_val[XW-1] && (KW'(x_val) < KW'({w_lim, 16'h0000}));
    assign y_ok      = !y_val[XW-1] && (KW'(y_val) < KW'({h_lim, 16'h0000}));
    assign pt_inside = x_ok && y_ok;

    // outside count, restarted by index zero, saturating
    always_comb
    begin
        tally_base = (idx_reg == '0) ? '0 : tally_reg;
        tally_next = tally_base;
        if (!pt_inside && (tally_base != {COUNT_W{1'b1}}))
            tally_next = tally_base + 1'b1;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_DIV;
            S_DIV:  if (div_last) state_next = S_ORI;
            S_ORI:  if (trig.done) state_next = S_PHS;
            S_PHS:  if (trig.done) state_next = S_MUL;
            S_MUL:  if (mstep_reg == M_YB) state_next = S_FIN;
            S_FIN:  if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            mstep_reg     <= M_DX;
            out_valid_reg <= 1'b0;
            tally_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                div_cnt_reg <= '0;
            else if (state_reg == S_DIV)
                div_cnt_reg <= div_cnt_reg + 1'b1;
            if (state_reg == S_MUL)
                mstep_reg <= mul_step_t'(mstep_reg + 3'd1);
            else
                mstep_reg <= M_DX;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                tally_reg     <= tally_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= point_index;
            dvd_reg <= point_index;
            rem_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            dvd_reg <= {dvd_reg[INDEX_W-2:0], 1'b0};
            rem_reg <= rem_ge ? rem_sub[15:0] : rem_sh[15:0];
            q_reg   <= {q_reg[ANGLE_BITS-2:0], rem_ge};
        end
        if ((state_reg == S_ORI) && trig.done)
        begin
            so_reg <= trig.sin_val;
            co_reg <= trig.cos_val;
        end
        if ((state_reg == S_PHS) && trig.done)
        begin
            sp_reg <= trig.sin_val;
            cp_reg <= trig.cos_val;
        end
        if (state_reg == S_MUL)
        begin
            case (mstep_reg)
                M_DX:    dx_reg   <= prod[DW-1:0];
                M_DY:    dy_reg   <= prod[DW-1:0];
                M_XA:    accx_reg <= prod_ext;
                M_XB:    accx_reg <= accx_reg - prod_ext;
                M_YA:    accy_reg <= prod_ext;
                M_YB:    accy_reg <= accy_reg + prod_ext;
                default: ;
            endcase
        end
        if (load_out)
        begin
            inside_reg <= pt_inside;
            column_reg <= pt_inside ? x_val[16 +: PIXEL_W] : '0;
            row_reg    <= pt_inside ? (h_lim[PIXEL_W-1:0] - 1'b1 - y_val[16 +: PIXEL_W])
                                    : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign column        = column_reg;
    assign row           = row_reg;
    assign inside_res    = inside_reg;
    assign outside_count = tally_reg;

    // rotator is idle whenever it is started
    assert property (@(posedge clk) disable iff (!rst_n)
        trig_start |-> !trig.busy)
        else $error("rotator started while busy");

    // no second word is taken right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input taken twice in a row");

    // multiplies only see settled sine and cosine
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> !trig.busy)
        else $error("multiply during rotation");

    // an outside point shows zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !inside_res) |-> (column == '0 && row == '0))
        else $error("outside point with nonzero pixel");

endmodule

`default_nettype wire

>>> bench/tb_rotated_ellipse_point_generator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotated_ellipse_point_generator_unit: self-checking bench for the
// rotated ellipse point generator
// Programs the ellipse and image settings while the unit is idle, sends
// point indexes and predicts every pixel word with a bit-exact CORDIC
// model. A checker compares each word taken from the output channel with
// the oldest prediction. Both channels idle at random, and the output is
// held off for a long stretch to stall the input.
// ----------------------------------------------------------------------------

module tb_rotated_ellipse_point_generator_unit;

    import repg_pkg::*;

    localparam int     SETTLE_CYCLES = 100;
    localparam longint CYCLE_LIMIT   = 2000000;
    localparam int     TRIG_STEPS    = 16;
    localparam longint PIXEL_SPAN    = 4096;
    localparam longint GAIN_Q30      = 652032874;
    localparam int     RANDOM_PHASES = 8;
    localparam int     PHASE_ITEMS   = 195;

    // one pixel word from the output channel
    typedef struct packed {
        logic [PIXEL_W-1:0] column;
        logic [PIXEL_W-1:0] row;
        logic               in_image;
        logic [COUNT_W-1:0] count;
    } point_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [INDEX_W-1:0]     point_index = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [PIXEL_W-1:0]     column;
    logic [PIXEL_W-1:0]     row;
    logic                   inside_res;
    logic [COUNT_W-1:0]     outside_count;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // shadow of the settings and the outside tally
    logic [11:0] ctr_x = 12'd0;
    logic [11:0] ctr_y = 12'd0;
    logic [11:0] axis_a = 12'd1;
    logic [11:0] axis_b = 12'd1;
    logic [15:0] tilt = 16'd0;
    logic [15:0] pts_per_turn = 16'd3;
    logic [12:0] img_w = 13'd4096;
    logic [12:0] img_h = 13'd4096;
    logic [15:0] outside_run = 16'd0;

    // arctangent of 2^-k, 32-bit fraction of a turn
    longint atan_turn [0:TRIG_STEPS-1] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    point_word_t expected_points[$];
    int          mismatches = 0;
    longint      cycle_count = 0;
    int          hold_request = 0;
    bit          steady_flow = 1'b0;

    rotated_ellipse_point_generator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .point_index   (point_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .column        (column),
        .row           (row),
        .inside_res    (inside_res),
        .outside_count (outside_count),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // q2.30 to q1.15 with rounding and saturation
    function automatic longint round_q15(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    // cordic sine and cosine of a 32-bit fraction of a turn
    function automatic void trig_pair(input logic [31:0] turn,
                                      output longint sin_q15,
                                      output longint cos_q15);
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        logic [31:0] r;
        bit          flip;
        r = turn;
        flip = (r[31:30] == 2'b01) || (r[31:30] == 2'b10);
        if (flip)
            r = r - 32'h8000_0000;
        x = GAIN_Q30;
        y = 0;
        z = longint'($signed(r));
        for (int k = 0; k < TRIG_STEPS; k++)
        begin
            xs = x >>> k;
            ys = y >>> k;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_turn[k];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_turn[k];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cos_q15 = round_q15(x);
        sin_q15 = round_q15(y);
    endfunction

    // pixel word for one index, updates the outside tally
    function automatic point_word_t predict_point(input logic [15:0] idx);
        longint      phase;
        longint      sp;
        longint      cp;
        longint      so;
        longint      co;
        longint      dx;
        longint      dy;
        longint      px;
        longint      py;
        longint      w;
        longint      h;
        longint      flipped;
        bit          in_img;
        point_word_t p;
        phase = 0;
        if (pts_per_turn != 0)
            phase = ((longint'(idx) << 16) / longint'(pts_per_turn)) & 64'hFFFF;
        trig_pair({phase[15:0], 16'h0000}, sp, cp);
        trig_pair({tilt, 16'h0000}, so, co);
        dx = longint'(axis_a) * cp;
        dy = longint'(axis_b) * sp;
        px = ((dx * co - dy * so) >>> 14) + (longint'(ctr_x) << 16);
        py = ((dx * so + dy * co) >>> 14) + (longint'(ctr_y) << 16);
        w = (img_w > PIXEL_SPAN) ? PIXEL_SPAN : longint'(img_w);
        h = (img_h > PIXEL_SPAN) ? PIXEL_SPAN : longint'(img_h);
        in_img = (px >= 0) && (px < (w << 16)) && (py >= 0) && (py < (h << 16));
        if (idx == 0)
            outside_run = 16'd0;
        if (!in_img && outside_run != 16'hFFFF)
            outside_run = outside_run + 16'd1;
        flipped = h - 1 - (py >>> 16);
        p.column = in_img ? px[27:16] : '0;
        p.row = in_img ? flipped[11:0] : '0;
        p.in_image = in_img;
        p.count = outside_run;
        return p;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    // random value with the ends of the range favored
    function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return lo;
        else if (r == 1)
            return hi;
        return $urandom_range(lo, hi);
    endfunction

    // one register write, then the write enable is driven low again
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CENTER_X:     ctr_x = val[11:0];
            CFG_CENTER_Y:     ctr_y = val[11:0];
            CFG_SEMI_AXIS_A:  axis_a = val[11:0];
            CFG_SEMI_AXIS_B:  axis_b = val[11:0];
            CFG_ORIENTATION:  tilt = val;
            CFG_N_POINTS:     pts_per_turn = val;
            CFG_IMAGE_WIDTH:  img_w = val[12:0];
            CFG_IMAGE_HEIGHT: img_h = val[12:0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_settings(input int cx, input int cy, input int a, input int b,
                                    input int orient, input int n, input int w,
                                    input int h);
        write_reg(CFG_CENTER_X, 16'(cx));
        write_reg(CFG_CENTER_Y, 16'(cy));
        write_reg(CFG_SEMI_AXIS_A, 16'(a));
        write_reg(CFG_SEMI_AXIS_B, 16'(b));
        write_reg(CFG_ORIENTATION, 16'(orient));
        write_reg(CFG_N_POINTS, 16'(n));
        write_reg(CFG_IMAGE_WIDTH, 16'(w));
        write_reg(CFG_IMAGE_HEIGHT, 16'(h));
    endtask

    // offer one index, predict at accept; valid stays high when no gap follows
    task automatic send_index(input logic [15:0] idx);
        int gap;
        in_valid <= 1'b1;
        point_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        expected_points.push_back(predict_point(idx));
        gap = steady_flow ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait until every word has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // output side: random gaps per word, long hold-off on request
    initial
    begin
        int gap;
        int held;
        forever
        begin
            if (hold_request > 0)
            begin
                held = hold_request;
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (held) @(posedge clk);
            end
            else
            begin
                gap = steady_flow ? 0 : gap_len();
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                out_ready <= 1'b1;
                do
                    @(posedge clk);
                while (!out_valid && hold_request == 0);
            end
        end
    end

    // compare each taken word with the oldest prediction
    always @(posedge clk)
    begin
        point_word_t want;
        point_word_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{column, row, inside_res, outside_count};
            if (expected_points.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word col %0d row %0d in %0d cnt %0d",
                         $time, column, row, inside_res, outside_count);
            end
            else
            begin
                want = expected_points.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    // column/row/inside/count
                    $display("%0t: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                             $time, want.column, want.row, want.in_image, want.count,
                             got.column, got.row, got.in_image, got.count);
                end
            end
        end
    end

    // reset settings, index wrap past the point count, all index bits set
    task automatic test_reset_defaults();
        send_index(16'd0);
        send_index(16'd1);
        send_index(16'd2);
        send_index(16'hFFFF);
        wait_for_results();
    endtask

    // largest and smallest settings, image size clamped to the pixel range
    task automatic test_extreme_settings();
        program_settings(4095, 4095, 4095, 4095, 16'hFFFF, 16'hFFFF, 8191, 8191);
        send_index(16'd0);
        send_index(16'd16384);
        send_index(16'd32768);
        send_index(16'd49151);
        wait_for_results();
        program_settings(0, 0, 1, 1, 0, 3, 1, 1);
        send_index(16'd0);
        send_index(16'd1);
        wait_for_results();
    endtask

    // zero point count, zero axis, empty image, point count below three
    task automatic test_degenerate_settings();
        program_settings(2048, 2048, 0, 300, 0, 0, 0, 4096);
        send_index(16'd0);
        send_index(16'd7);
        wait_for_results();
        program_settings(2048, 2048, 300, 300, 0, 2, 4096, 4096);
        send_index(16'd1);
        send_index(16'd3);
        wait_for_results();
    endtask

    // one full turn of a tilted ellipse inside a short image
    task automatic test_full_turn();
        program_settings(2000, 1500, 1500, 700, 8192, 10, 4096, 3000);
        for (int i = 0; i < 10; i++)
            send_index(16'(i));
        wait_for_results();
    endtask

    // output held off while indexes keep coming, input must stall
    task automatic test_output_backpressure();
        hold_request = 400;
        for (int i = 0; i < 12; i++)
            send_index(16'(i));
        wait_for_results();
    endtask

    // sender pauses until all words are back, tally carries on afterwards
    task automatic test_drain_pause();
        for (int i = 0; i < 5; i++)
            send_index(16'(i));
        wait_for_results();
        for (int i = 5; i < 10; i++)
            send_index(16'(i));
        wait_for_results();
    endtask

    // mostly runs from index zero, some stray and out-of-range indexes
    task automatic send_index_mix(input int quota);
        int sent;
        int len;
        int n;
        int r;
        sent = 0;
        n = int'(pts_per_turn);
        while (sent < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                if (n <= 48)
                begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
                    for (int i = 0; i < len; i++)
                        send_index(16'(i));
                end
                else
                begin
                    len = $urandom_range(8, 48);
                    for (int i = 0; i < len; i++)
                        send_index(16'(i * (n / len)));
                    send_index(16'(n - 1));
                    len++;
                end
                sent += len;
            end
            else if (r < 90)
            begin
                send_index(16'($urandom_range(0, 65535)));
                sent++;
            end
            else
            begin
                send_index(16'($urandom_range(n, 65535)));
                sent++;
            end
        end
    endtask

    task automatic test_random_settings();
        int n;
        int w;
        int h;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            n = ($urandom_range(0, 3) != 0) ? $urandom_range(3, 40) : pick(3, 65535);
            w = ($urandom_range(0, 6) != 0) ? pick(1, 4096) : $urandom_range(4097, 8191);
            h = ($urandom_range(0, 6) != 0) ? pick(1, 4096) : $urandom_range(4097, 8191);
            program_settings(pick(0, 4095), pick(0, 4095), pick(1, 4095), pick(1, 4095),
                             pick(0, 65535), n, w, h);
            steady_flow = (ph == 3);
            send_index_mix(PHASE_ITEMS);
            wait_for_results();
            steady_flow = 1'b0;
        end
    endtask

    // test sequence
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_extreme_settings();
        test_degenerate_settings();
        test_full_turn();
        test_output_backpressure();
        test_drain_pause();
        test_random_settings();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
sv/repg_pkg.sv
sv/repg_cordic.sv
sv/rotated_ellipse_point_generator_unit.sv
bench/tb_rotated_ellipse_point_generator_unit.sv
